### hw/rtl/poly_voice_allocator_assert.svh
`ifndef POLY_VOICE_ALLOCATOR_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define PVA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define PVA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

### hw/rtl/pva_pkg.sv
package pva_pkg;

   localparam int VOICES_DEF = 16;
   localparam int CELLS      = 64;

   localparam int KIND_W  = 2;
   localparam int CELL_W  = 6;
   localparam int NOTE_W  = 7;
   localparam int AGE_W   = 64;
   localparam int RR_W    = 32;
   localparam int MP_W    = 5;
   localparam int MODE_W  = 3;
   localparam int VOICE_W = 4;
   localparam int GATE_W  = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 3;

   localparam logic [MP_W-1:0] MAX_POLY_RST = 5'd8;

   localparam logic [KIND_W-1:0] KIND_PRESS       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE_ALL = 2'd2;

   localparam logic [MODE_W-1:0] MODE_OLDEST      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NEWEST      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LOWEST      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_HIGHEST     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_POLY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEAL_MODE = 2'd1;

   typedef struct packed {
      logic clear;
      logic vld;
      logic first;
      logic hit;
      logic free;
      logic less;
      logic use_age;
   } scan_ctl_type;

   typedef struct packed {
      logic match_found;
      logic free_found;
   } scan_res_type;

endpackage

### hw/rtl/pva_ram.sv
module pva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/pva_scan.sv
module pva_scan #(
   parameter int VOICES = pva_pkg::VOICES_DEF,
   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  pva_pkg::scan_ctl_type      ctl,
   input  logic [IW-1:0]              idx,
   input  logic [pva_pkg::NOTE_W-1:0] pitch,
   input  logic [pva_pkg::AGE_W-1:0]  age,
   output pva_pkg::scan_res_type      res,
   output logic [IW-1:0]              match_idx,
   output logic [IW-1:0]              free_idx,
   output logic [IW-1:0]              victim_idx
);
   import pva_pkg::*;

   scan_res_type     res_ff, res_in;
   logic [IW-1:0]    match_idx_ff, match_idx_in;
   logic [IW-1:0]    free_idx_ff, free_idx_in;
   logic [IW-1:0]    best_idx_ff, best_idx_in;
   logic [AGE_W-1:0] best_key_ff, best_key_in;
   logic [AGE_W-1:0] key;
   logic             better;

   always_comb begin
      key    = ctl.use_age ? age : AGE_W'(pitch);
      better = ctl.less ? (key < best_key_ff) : (key > best_key_ff);

      res_in       = res_ff;
      match_idx_in = match_idx_ff;
      free_idx_in  = free_idx_ff;
      best_idx_in  = best_idx_ff;
      best_key_in  = best_key_ff;

      if (ctl.clear) begin
         res_in = '0;
      end else if (ctl.vld) begin
         if (ctl.hit && !res_ff.match_found) begin
            res_in.match_found = 1'b1;
            match_idx_in       = idx;
         end
         if (ctl.free && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            free_idx_in       = idx;
         end
         if (ctl.first || better) begin
            best_idx_in = idx;
            best_key_in = key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      best_idx_ff  <= best_idx_in;
      best_key_ff  <= best_key_in;
   end

   assign res        = res_ff;
   assign match_idx  = match_idx_ff;
   assign free_idx   = free_idx_ff;
   assign victim_idx = best_idx_ff;

endmodule

### hw/rtl/pva_rem.sv
module pva_rem #(
   parameter int VOICES = pva_pkg::VOICES_DEF,
   localparam int PW = $clog2(VOICES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [pva_pkg::RR_W-1:0] dividend,
   input  logic [PW-1:0]            divisor,
   output logic                     done,
   output logic [PW-1:0]            rem
);
   import pva_pkg::*;

   localparam int CNT_W = $clog2(RR_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RR_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RR_W-1:0]   dvd_ff, dvd_in;
   logic [PW-1:0]     div_ff, div_in;
   logic [PW-1:0]     rem_ff, rem_in;
   logic [PW:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[RR_W-1]};

      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = PW'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[PW-1:0];
         end
         dvd_in = {dvd_ff[RR_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

### hw/rtl/poly_voice_allocator.sv
// Requests are handled one at a time: for each press or release of a valid cell the voice
// memory is read once per voice in use (poly) through its single read port.
// Reset (synchronous, active high) clears all gates, the age and round-robin
// counters and the registers (max_poly 8, oldest steal); the voice memory is not swept.
`include "poly_voice_allocator_assert.svh"

module poly_voice_allocator #(
   parameter int VOICES = pva_pkg::VOICES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pva_pkg::REQ_DATA_W-1:0] req_tdata,  // cell_req, note
   input  logic [pva_pkg::REQ_USER_W-1:0] req_tuser,  // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pva_pkg::RSP_DATA_W-1:0] rsp_tdata,  // voice, voice_note, gate_mask
   output logic [pva_pkg::RSP_USER_W-1:0] rsp_tuser,  // started, stolen, dropped
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pva_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pva_pkg::CSR_DATA_W-1:0] csr_data
);
   import pva_pkg::*;

   localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int PW = $clog2(VOICES + 1);
   localparam int XW = (PW > MP_W) ? PW : MP_W;
   localparam int EW = CELL_W + NOTE_W + AGE_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_MOD   = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [MP_W-1:0]   max_poly_ff, max_poly_in;
   logic [MODE_W-1:0] steal_mode_ff, steal_mode_in;
   logic [VOICES-1:0] active_ff, active_in;
   logic [AGE_W-1:0]  age_ff, age_in;
   logic [RR_W-1:0]   rr_ff, rr_in;
   logic [PW-1:0]     issue_ff, issue_in;
   logic              dv_ff, dv_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;
   logic [NOTE_W-1:0]     note_ff, note_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [IW-1:0]         target_ff, target_in;
   logic                  started_ff, started_in;
   logic                  stolen_ff, stolen_in;
   logic                  dropped_ff, dropped_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic [CELL_W-1:0] req_cell;
   logic [NOTE_W-1:0] req_note;
   logic              req_acc;
   logic              cell_ok;
   logic [XW-1:0]     mp_x;
   logic [PW-1:0]     poly;

   logic              rd_en;
   logic              wr_en;
   logic [EW-1:0]     wr_data;
   logic [EW-1:0]     rd_data;
   logic [CELL_W-1:0] rd_cell;
   logic [NOTE_W-1:0] rd_pitch;
   logic [AGE_W-1:0]  rd_age;
   logic              hit;

   scan_ctl_type  scan_ctl;
   scan_res_type  scan_res;
   logic [IW-1:0] match_idx;
   logic [IW-1:0] free_idx;
   logic [IW-1:0] victim_idx;

   logic          rem_start;
   logic          rem_done;
   logic [PW-1:0] rem_val;

   assign req_cell   = req_tdata[CELL_W-1:0];
   assign req_note   = req_tdata[CELL_W+NOTE_W-1:CELL_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign cell_ok    = (int'(req_cell) < CELLS);
   assign csr_ready  = 1'b1;

   assign rd_cell  = rd_data[EW-1:NOTE_W+AGE_W];
   assign rd_pitch = rd_data[NOTE_W+AGE_W-1:AGE_W];
   assign rd_age   = rd_data[AGE_W-1:0];
   assign hit      = active_ff[idx_ff] && (rd_cell == cell_ff);

   always_comb begin
      mp_x = XW'(max_poly_ff);
      if (mp_x == '0) begin
         poly = PW'(1);
      end else if (mp_x > XW'(VOICES)) begin
         poly = PW'(VOICES);
      end else begin
         poly = PW'(mp_x);
      end
   end

   always_comb begin
      state_in      = state_ff;
      max_poly_in   = max_poly_ff;
      steal_mode_in = steal_mode_ff;
      active_in     = active_ff;
      age_in        = age_ff;
      rr_in         = rr_ff;
      issue_in      = issue_ff;
      dv_in         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      kind_in       = kind_ff;
      cell_in       = cell_ff;
      note_in       = note_ff;
      idx_in        = idx_ff;
      target_in     = target_ff;
      started_in    = started_ff;
      stolen_in     = stolen_ff;
      dropped_in    = dropped_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_data       = {cell_ff, note_ff, age_ff + 1'b1};
      rem_start     = 1'b0;

      scan_ctl.clear   = 1'b0;
      scan_ctl.vld     = dv_ff && (kind_ff == KIND_PRESS);
      scan_ctl.first   = (idx_ff == '0);
      scan_ctl.hit     = hit;
      scan_ctl.free    = !active_ff[idx_ff];
      scan_ctl.less    = (steal_mode_ff == MODE_OLDEST) || (steal_mode_ff == MODE_LOWEST);
      scan_ctl.use_age = (steal_mode_ff == MODE_OLDEST) || (steal_mode_ff == MODE_NEWEST);

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MAX_POLY:   max_poly_in   = csr_data[MP_W-1:0];
            REG_STEAL_MODE: steal_mode_in = csr_data[MODE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               kind_in        = req_tuser;
               cell_in        = req_cell;
               note_in        = req_note;
               target_in      = '0;
               started_in     = 1'b0;
               stolen_in      = 1'b0;
               dropped_in     = 1'b0;
               issue_in       = '0;
               scan_ctl.clear = 1'b1;
               priority if (((req_tuser == KIND_PRESS) || (req_tuser == KIND_RELEASE))
                            && cell_ok) begin
                  state_in = ST_SCAN;
               end else if (req_tuser == KIND_RELEASE_ALL) begin
                  active_in = '0;
                  state_in  = ST_RESP;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            rd_en = (issue_ff < poly);
            dv_in = rd_en;
            if (rd_en) begin
               idx_in   = issue_ff[IW-1:0];
               issue_in = issue_ff + 1'b1;
            end
            if (dv_ff && (kind_ff == KIND_RELEASE) && hit) begin
               active_in[idx_ff] = 1'b0;
            end
            if (!rd_en && !dv_ff) begin
               if (kind_ff == KIND_RELEASE) begin
                  state_in = ST_RESP;
               end else begin
                  priority if (scan_res.match_found) begin
                     target_in = match_idx;
                     state_in  = ST_WRITE;
                  end else if (scan_res.free_found) begin
                     target_in = free_idx;
                     state_in  = ST_WRITE;
                  end else if (steal_mode_ff <= MODE_HIGHEST) begin
                     target_in = victim_idx;
                     stolen_in = 1'b1;
                     state_in  = ST_WRITE;
                  end else if (steal_mode_ff == MODE_ROUND_ROBIN) begin
                     rem_start = 1'b1;
                     stolen_in = 1'b1;
                     state_in  = ST_MOD;
                  end else begin
                     dropped_in = 1'b1;
                     state_in   = ST_RESP;
                  end
               end
            end
         end
         ST_MOD: begin
            if (rem_done) begin
               target_in = rem_val[IW-1:0];
               rr_in     = rr_ff + 1'b1;
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en                = 1'b1;
            age_in               = age_ff + 1'b1;
            active_in[target_ff] = 1'b1;
            started_in           = 1'b1;
            state_in             = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({GATE_W'(active_ff),
                                           started_ff ? note_ff : NOTE_W'(0),
                                           started_ff ? VOICE_W'(target_ff) : VOICE_W'(0)});
               rsp_user_in  = {dropped_ff, stolen_ff, started_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_poly_ff   <= MAX_POLY_RST;
         steal_mode_ff <= MODE_OLDEST;
         active_ff     <= '0;
         age_ff        <= '0;
         rr_ff         <= '0;
         issue_ff      <= '0;
         dv_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         max_poly_ff   <= max_poly_in;
         steal_mode_ff <= steal_mode_in;
         active_ff     <= active_in;
         age_ff        <= age_in;
         rr_ff         <= rr_in;
         issue_ff      <= issue_in;
         dv_ff         <= dv_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      cell_ff     <= cell_in;
      note_ff     <= note_in;
      idx_ff      <= idx_in;
      target_ff   <= target_in;
      started_ff  <= started_in;
      stolen_ff   <= stolen_in;
      dropped_ff  <= dropped_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   pva_ram #(
      .WIDTH (EW),
      .DEPTH (VOICES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (target_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   pva_scan #(
      .VOICES (VOICES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .idx        (idx_ff),
      .pitch      (rd_pitch),
      .age        (rd_age),
      .res        (scan_res),
      .match_idx  (match_idx),
      .free_idx   (free_idx),
      .victim_idx (victim_idx)
   );

   pva_rem #(
      .VOICES (VOICES)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rr_ff),
      .divisor  (poly),
      .done     (rem_done),
      .rem      (rem_val)
   );

   `PVA_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, state_ff != ST_IDLE)
   `PVA_ASSERT_NEXT(a_write_gate, clock, reset, state_ff == ST_WRITE, active_ff[target_ff])
   `PVA_ASSERT_IMPL(a_target_range, clock, reset, state_ff == ST_WRITE, target_ff < poly)
   `PVA_ASSERT_IMPL(a_mod_mode, clock, reset, state_ff == ST_MOD, steal_mode_ff == MODE_ROUND_ROBIN)

endmodule
